@@ rtl/hsvcm_pkg.sv @@
`timescale 1ns / 1ps
package hsvcm_pkg;

   localparam int MAX_PIXELS = 1048576;
   localparam int CNT_W      = 21;
   localparam int PIX_W      = 8;
   localparam int SQ_W       = 16;
   localparam int CUBE_W     = 24;
   localparam int S1_W       = 28;
   localparam int S2_W       = 36;
   localparam int S3_W       = 44;
   localparam int D_W        = 56;
   localparam int N2_W       = 41;
   localparam int RES_W      = 16;
   localparam int NUM_CH     = 3;
   localparam int CH_W       = 2;

   // wide multiply: limb-serial over a 32x32 multiplier
   localparam int WIDE_W     = 256;
   localparam int LIMB_W     = 32;
   localparam int LIMB_SH    = 5;
   localparam int NLIMB      = WIDE_W / LIMB_W;
   localparam int LIMB_IX_W  = 3;

   localparam int STEP_W     = 4;
   localparam int NUM_STEPS  = 10;

   localparam logic [RES_W-1:0] CAP_FULL = 16'hFFFF;
   localparam logic [RES_W-1:0] CAP_POS  = 16'h7FFF;
   localparam logic [RES_W-1:0] CAP_NEG  = 16'h8000;

   typedef enum logic [3:0] {
      SRC_N, SRC_NX2, SRC_N3, SRC_S1, SRC_S1X2, SRC_S2, SRC_S3, SRC_S1SQ,
      SRC_N2, SRC_D, SRC_TMP, SRC_TSH, SRC_NEG, SRC_MID, SRC_MIDSQ
   } src_type;

   typedef enum logic [2:0] {
      DST_TMP, DST_S1SQ_D, DST_N2, DST_POS, DST_POS_ADD, DST_T, DST_NEG
   } dst_type;

   typedef enum logic [1:0] {
      SRCH_MEAN, SRCH_DEV, SRCH_SKEW
   } srch_type;

   typedef enum logic [2:0] {
      OP_NOP, OP_LOAD, OP_WRITE, OP_SINIT, OP_SSTEP, OP_SSAVE, OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      src_type          opa;
      src_type          opb;
      dst_type          dst;
      srch_type         srch;
      logic [CH_W-1:0]  ch;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic srch_done;
      logic out_full;
   } dp_stat_type;

   typedef struct packed {
      logic fin;
      logic hold;
   } acc_stat_type;

   typedef struct packed {
      src_type opa;
      src_type opb;
      dst_type dst;
   } ustep_type;

   // per-channel sequence of wide products ahead of the three searches
   function automatic ustep_type ustep(input logic [STEP_W-1:0] idx);
      ustep_type u;
      case (idx)
         4'd0: u = '{opa: SRC_N,    opb: SRC_S2,   dst: DST_TMP};
         4'd1: u = '{opa: SRC_S1,   opb: SRC_S1,   dst: DST_S1SQ_D};
         4'd2: u = '{opa: SRC_N,    opb: SRC_N,    dst: DST_N2};
         4'd3: u = '{opa: SRC_N2,   opb: SRC_S3,   dst: DST_POS};
         4'd4: u = '{opa: SRC_S1SQ, opb: SRC_S1X2, dst: DST_POS_ADD};
         4'd5: u = '{opa: SRC_N3,   opb: SRC_S1,   dst: DST_TMP};
         4'd6: u = '{opa: SRC_TMP,  opb: SRC_S2,   dst: DST_T};
         4'd7: u = '{opa: SRC_TSH,  opb: SRC_TSH,  dst: DST_POS};
         4'd8: u = '{opa: SRC_D,    opb: SRC_D,    dst: DST_TMP};
         4'd9: u = '{opa: SRC_TMP,  opb: SRC_D,    dst: DST_NEG};
         default: u = '{opa: SRC_N, opb: SRC_S2,   dst: DST_TMP};
      endcase
      return u;
   endfunction

endpackage

@@ rtl/hsv_color_moments_core.sv @@
`timescale 1ns / 1ps
// Color moments of an HSV pixel region.
// Input channel (req_): one pixel word per handshake, three 8-bit channels
// plus last_pixel. Pixels are taken at one per cycle while a region streams.
// Up to 1048576 pixels per region are summed; later ones are dropped and
// reported through rsp_too_many.
// After the word marked last_pixel is taken, req_ready drops while the
// moments are worked out: each of the three channels runs 10 wide products
// and three binary searches of 15 to 16 steps, all on one shared 32x32
// multiplier that forms each 256-bit product limb by limb.
// Result channel (rsp_): one word per region with mean and deviation in
// unsigned Q8.8, saturated skew in signed Q7.8, flat flags and the drop flag.
// The result sits in an output register; the next region streams in while
// it waits, and only its own finish waits if the receiver still stalls.
// Reset clears all sums, the pixel count, the drop flag and any pending word.
module hsv_color_moments_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [hsvcm_pkg::PIX_W-1:0]           req_hue,
   input  logic [hsvcm_pkg::PIX_W-1:0]           req_saturation,
   input  logic [hsvcm_pkg::PIX_W-1:0]           req_brightness,
   input  logic                                  req_last_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [hsvcm_pkg::RES_W-1:0]           rsp_hue_mean,
   output logic [hsvcm_pkg::RES_W-1:0]           rsp_sat_mean,
   output logic [hsvcm_pkg::RES_W-1:0]           rsp_bright_mean,
   output logic [hsvcm_pkg::RES_W-1:0]           rsp_hue_dev,
   output logic [hsvcm_pkg::RES_W-1:0]           rsp_sat_dev,
   output logic [hsvcm_pkg::RES_W-1:0]           rsp_bright_dev,
   output logic signed [hsvcm_pkg::RES_W-1:0]    rsp_hue_skew,
   output logic signed [hsvcm_pkg::RES_W-1:0]    rsp_sat_skew,
   output logic signed [hsvcm_pkg::RES_W-1:0]    rsp_bright_skew,
   output logic [2:0]                            rsp_flat_flags,
   output logic                                  rsp_too_many
);
   import hsvcm_pkg::*;

   logic                    accept, acc_clear, dropped;
   logic [CNT_W-1:0]        n;
   logic [2:0][S1_W-1:0]    s1;
   logic [2:0][S2_W-1:0]    s2;
   logic [2:0][S3_W-1:0]    s3;
   acc_stat_type            acc_stat;
   dp_stat_type             dp_stat;
   dp_cmd_type              cmd;

   assign accept = req_valid && req_ready;

   hsvcm_acc u_acc (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .last_pixel (req_last_pixel),
      .clear      (acc_clear),
      .n          (n),
      .s1         (s1),
      .s2         (s2),
      .s3         (s3),
      .dropped    (dropped),
      .stat       (acc_stat)
   );

   hsvcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .acc_stat  (acc_stat),
      .stat      (dp_stat),
      .cmd       (cmd),
      .acc_clear (acc_clear),
      .req_ready (req_ready)
   );

   hsvcm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .n               (n),
      .s1              (s1),
      .s2              (s2),
      .s3              (s3),
      .dropped         (dropped),
      .stat            (dp_stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hue_mean    (rsp_hue_mean),
      .rsp_sat_mean    (rsp_sat_mean),
      .rsp_bright_mean (rsp_bright_mean),
      .rsp_hue_dev     (rsp_hue_dev),
      .rsp_sat_dev     (rsp_sat_dev),
      .rsp_bright_dev  (rsp_bright_dev),
      .rsp_hue_skew    (rsp_hue_skew),
      .rsp_sat_skew    (rsp_sat_skew),
      .rsp_bright_skew (rsp_bright_skew),
      .rsp_flat_flags  (rsp_flat_flags),
      .rsp_too_many    (rsp_too_many)
   );

   a_fin_single: assert property (@(posedge clock) disable iff (reset)
      acc_stat.fin |=> !acc_stat.fin)
      else $error("finish request repeated");

   a_mul_idle_input: assert property (@(posedge clock) disable iff (reset)
      dp_stat.mul_done |-> !req_ready)
      else $error("multiplier busy while pixels are taken");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |-> !rsp_valid)
      else $error("pending result overwritten");

endmodule

@@ rtl/hsvcm_acc.sv @@
`timescale 1ns / 1ps
module hsvcm_acc (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     accept,
   input  logic [hsvcm_pkg::PIX_W-1:0]              hue,
   input  logic [hsvcm_pkg::PIX_W-1:0]              saturation,
   input  logic [hsvcm_pkg::PIX_W-1:0]              brightness,
   input  logic                                     last_pixel,
   input  logic                                     clear,
   output logic [hsvcm_pkg::CNT_W-1:0]              n,
   output logic [2:0][hsvcm_pkg::S1_W-1:0]          s1,
   output logic [2:0][hsvcm_pkg::S2_W-1:0]          s2,
   output logic [2:0][hsvcm_pkg::S3_W-1:0]          s3,
   output logic                                     dropped,
   output hsvcm_pkg::acc_stat_type                  stat
);
   import hsvcm_pkg::*;

   logic                       v1_ff, last1_ff, fin_ff;
   logic [2:0][PIX_W-1:0]      x1_ff;
   logic [2:0][SQ_W-1:0]       sq1_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [2:0][S1_W-1:0]       s1_ff;
   logic [2:0][S2_W-1:0]       s2_ff;
   logic [2:0][S3_W-1:0]       s3_ff;
   logic                       drop_ff;
   logic [2:0][PIX_W-1:0]      x_in;
   logic [2:0][CUBE_W-1:0]     cube;

   assign x_in = {brightness, saturation, hue};

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         cube[c] = CUBE_W'(sq1_ff[c]) * CUBE_W'(x1_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         fin_ff <= v1_ff && last1_ff;
      end
   end

   always_ff @(posedge clock) begin
      last1_ff <= last_pixel;
      for (int c = 0; c < NUM_CH; c++) begin
         x1_ff[c] <= x_in[c];
         sq1_ff[c] <= SQ_W'(x_in[c]) * SQ_W'(x_in[c]);
      end
   end

   // hold the count at capacity and flag the rest
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         cnt_ff <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         drop_ff <= 1'b0;
      end else if (v1_ff) begin
         if (cnt_ff < CNT_W'(MAX_PIXELS)) begin
            cnt_ff <= cnt_ff + 1'b1;
            for (int c = 0; c < NUM_CH; c++) begin
               s1_ff[c] <= s1_ff[c] + S1_W'(x1_ff[c]);
               s2_ff[c] <= s2_ff[c] + S2_W'(sq1_ff[c]);
               s3_ff[c] <= s3_ff[c] + S3_W'(cube[c]);
            end
         end else begin
            drop_ff <= 1'b1;
         end
      end
   end

   assign n = cnt_ff;
   assign s1 = s1_ff;
   assign s2 = s2_ff;
   assign s3 = s3_ff;
   assign dropped = drop_ff;
   assign stat.fin = fin_ff;
   assign stat.hold = (v1_ff && last1_ff) || fin_ff;

endmodule

@@ rtl/hsvcm_mul.sv @@
`timescale 1ns / 1ps
module hsvcm_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hsvcm_pkg::WIDE_W-1:0]  a,
   input  logic [hsvcm_pkg::WIDE_W-1:0]  b,
   output logic [hsvcm_pkg::WIDE_W-1:0]  prod,
   output logic                          done
);
   import hsvcm_pkg::*;

   logic                    run_ff, ppv_ff, done_ff, plast_ff;
   logic [LIMB_IX_W-1:0]    i_ff, j_ff;
   logic [LIMB_IX_W:0]      off_ff;
   logic [2*LIMB_W-1:0]     pp_ff;
   logic [WIDE_W-1:0]       prod_ff;
   logic [LIMB_W-1:0]       a_limb, b_limb;
   logic [WIDE_W-1:0]       term;
   logic                    at_end;

   assign a_limb = a[i_ff*LIMB_W +: LIMB_W];
   assign b_limb = b[j_ff*LIMB_W +: LIMB_W];
   assign at_end = (i_ff == LIMB_IX_W'(NLIMB-1)) && (j_ff == LIMB_IX_W'(NLIMB-1));

   // drop partial products that land above the word
   always_comb begin
      term = '0;
      if (!off_ff[LIMB_IX_W]) begin
         term = {{(WIDE_W-2*LIMB_W){1'b0}}, pp_ff} << {off_ff[LIMB_IX_W-1:0], {LIMB_SH{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         ppv_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         ppv_ff <= run_ff;
         done_ff <= ppv_ff && plast_ff;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && at_end) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         i_ff <= '0;
         j_ff <= '0;
      end else if (run_ff) begin
         j_ff <= j_ff + 1'b1;
         if (j_ff == LIMB_IX_W'(NLIMB-1)) begin
            i_ff <= i_ff + 1'b1;
         end
      end
      pp_ff <= (2*LIMB_W)'(a_limb) * (2*LIMB_W)'(b_limb);
      off_ff <= {1'b0, i_ff} + {1'b0, j_ff};
      plast_ff <= at_end;
      if (start) begin
         prod_ff <= '0;
      end else if (ppv_ff) begin
         prod_ff <= prod_ff + term;
      end
   end

   assign prod = prod_ff;
   assign done = done_ff;

endmodule

@@ rtl/hsvcm_dp.sv @@
`timescale 1ns / 1ps
module hsvcm_dp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  hsvcm_pkg::dp_cmd_type                    cmd,
   input  logic [hsvcm_pkg::CNT_W-1:0]              n,
   input  logic [2:0][hsvcm_pkg::S1_W-1:0]          s1,
   input  logic [2:0][hsvcm_pkg::S2_W-1:0]          s2,
   input  logic [2:0][hsvcm_pkg::S3_W-1:0]          s3,
   input  logic                                     dropped,
   output hsvcm_pkg::dp_stat_type                   stat,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [hsvcm_pkg::RES_W-1:0]              rsp_hue_mean,
   output logic [hsvcm_pkg::RES_W-1:0]              rsp_sat_mean,
   output logic [hsvcm_pkg::RES_W-1:0]              rsp_bright_mean,
   output logic [hsvcm_pkg::RES_W-1:0]              rsp_hue_dev,
   output logic [hsvcm_pkg::RES_W-1:0]              rsp_sat_dev,
   output logic [hsvcm_pkg::RES_W-1:0]              rsp_bright_dev,
   output logic signed [hsvcm_pkg::RES_W-1:0]       rsp_hue_skew,
   output logic signed [hsvcm_pkg::RES_W-1:0]       rsp_sat_skew,
   output logic signed [hsvcm_pkg::RES_W-1:0]       rsp_bright_skew,
   output logic [2:0]                               rsp_flat_flags,
   output logic                                     rsp_too_many
);
   import hsvcm_pkg::*;

   logic [WIDE_W-1:0]          opa_ff, opb_ff, tmp_ff, pos_ff, neg_ff;
   logic [D_W-1:0]             s1sq_ff, d_ff;
   logic [N2_W-1:0]            n2_ff;
   logic                       sgn_ff;
   logic [RES_W-1:0]           lo_ff, hi_ff;
   logic [2:0][RES_W-1:0]      mean_ff, dev_ff, skew_ff;
   logic [2:0]                 flat_ff;
   logic                       rsp_valid_ff;
   logic [2:0][RES_W-1:0]      omean_ff, odev_ff, oskew_ff;
   logic [2:0]                 oflat_ff;
   logic                       omany_ff;

   logic [WIDE_W-1:0]          prod, opa_in, opb_in, lhs;
   logic                       mul_done, pos_ge;
   logic [S1_W-1:0]            cs1;
   logic [S2_W-1:0]            cs2;
   logic [S3_W-1:0]            cs3;
   logic [CNT_W+1:0]           n3;
   logic [RES_W:0]             span;
   logic [RES_W-1:0]           mid, cap;
   logic [RES_W:0]             odd;
   logic [2*RES_W+1:0]         midsq;
   logic [S1_W+9:0]            lhs_mean;
   logic [D_W-1:0]             d_in;

   hsvcm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == OP_LOAD),
      .a     (opa_ff),
      .b     (opb_ff),
      .prod  (prod),
      .done  (mul_done)
   );

   always_comb begin
      case (cmd.ch)
         2'd0: begin
            cs1 = s1[0];
            cs2 = s2[0];
            cs3 = s3[0];
         end
         2'd1: begin
            cs1 = s1[1];
            cs2 = s2[1];
            cs3 = s3[1];
         end
         default: begin
            cs1 = s1[2];
            cs2 = s2[2];
            cs3 = s3[2];
         end
      endcase
   end

   assign n3 = {1'b0, n, 1'b0} + {2'b00, n};
   assign span = {1'b0, hi_ff} - {1'b0, lo_ff} + 1'b1;
   assign mid = lo_ff + span[RES_W:1];
   assign odd = {mid, 1'b0} - 1'b1;
   assign midsq = (2*RES_W+2)'(odd) * (2*RES_W+2)'(odd);
   assign lhs_mean = {1'b0, cs1, 9'd0} + (S1_W+10)'(n);
   assign d_in = tmp_ff[D_W-1:0] - prod[D_W-1:0];
   assign pos_ge = pos_ff >= prod;

   always_comb begin
      case (cmd.opa)
         SRC_N:     opa_in = WIDE_W'(n);
         SRC_NX2:   opa_in = WIDE_W'({n, 1'b0});
         SRC_N3:    opa_in = WIDE_W'(n3);
         SRC_S1:    opa_in = WIDE_W'(cs1);
         SRC_S1X2:  opa_in = WIDE_W'({cs1, 1'b0});
         SRC_S2:    opa_in = WIDE_W'(cs2);
         SRC_S3:    opa_in = WIDE_W'(cs3);
         SRC_S1SQ:  opa_in = WIDE_W'(s1sq_ff);
         SRC_N2:    opa_in = WIDE_W'(n2_ff);
         SRC_D:     opa_in = WIDE_W'(d_ff);
         SRC_TMP:   opa_in = tmp_ff;
         SRC_TSH:   opa_in = {tmp_ff[WIDE_W-10:0], 9'd0};
         SRC_NEG:   opa_in = neg_ff;
         SRC_MID:   opa_in = WIDE_W'(mid);
         SRC_MIDSQ: opa_in = WIDE_W'(midsq);
         default:   opa_in = '0;
      endcase
   end

   always_comb begin
      case (cmd.opb)
         SRC_N:     opb_in = WIDE_W'(n);
         SRC_NX2:   opb_in = WIDE_W'({n, 1'b0});
         SRC_N3:    opb_in = WIDE_W'(n3);
         SRC_S1:    opb_in = WIDE_W'(cs1);
         SRC_S1X2:  opb_in = WIDE_W'({cs1, 1'b0});
         SRC_S2:    opb_in = WIDE_W'(cs2);
         SRC_S3:    opb_in = WIDE_W'(cs3);
         SRC_S1SQ:  opb_in = WIDE_W'(s1sq_ff);
         SRC_N2:    opb_in = WIDE_W'(n2_ff);
         SRC_D:     opb_in = WIDE_W'(d_ff);
         SRC_TMP:   opb_in = tmp_ff;
         SRC_TSH:   opb_in = {tmp_ff[WIDE_W-10:0], 9'd0};
         SRC_NEG:   opb_in = neg_ff;
         SRC_MID:   opb_in = WIDE_W'(mid);
         SRC_MIDSQ: opb_in = WIDE_W'(midsq);
         default:   opb_in = '0;
      endcase
   end

   always_comb begin
      case (cmd.srch)
         SRCH_MEAN: begin
            lhs = WIDE_W'(lhs_mean);
            cap = CAP_FULL;
         end
         SRCH_DEV: begin
            lhs = WIDE_W'({d_ff, 18'd0});
            cap = CAP_FULL;
         end
         default: begin
            lhs = pos_ff;
            cap = sgn_ff ? CAP_NEG : CAP_POS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            opa_ff <= opa_in;
            opb_ff <= opb_in;
         end
         OP_WRITE: begin
            case (cmd.dst)
               DST_TMP:     tmp_ff <= prod;
               DST_S1SQ_D: begin
                  s1sq_ff <= prod[D_W-1:0];
                  d_ff <= d_in;
                  flat_ff[cmd.ch] <= (d_in == '0);
               end
               DST_N2:      n2_ff <= prod[N2_W-1:0];
               DST_POS:     pos_ff <= prod;
               DST_POS_ADD: pos_ff <= pos_ff + prod;
               DST_T: begin
                  tmp_ff <= pos_ge ? (pos_ff - prod) : (prod - pos_ff);
                  sgn_ff <= !pos_ge;
               end
               DST_NEG:     neg_ff <= prod;
               default:     tmp_ff <= prod;
            endcase
         end
         OP_SINIT: begin
            lo_ff <= '0;
            hi_ff <= cap;
         end
         OP_SSTEP: begin
            if (lhs >= prod) begin
               lo_ff <= mid;
            end else begin
               hi_ff <= mid - 1'b1;
            end
         end
         OP_SSAVE: begin
            case (cmd.srch)
               SRCH_MEAN: mean_ff[cmd.ch] <= lo_ff;
               SRCH_DEV:  dev_ff[cmd.ch] <= lo_ff;
               default: begin
                  if (flat_ff[cmd.ch]) begin
                     skew_ff[cmd.ch] <= '0;
                  end else if (sgn_ff) begin
                     skew_ff[cmd.ch] <= '0 - lo_ff;
                  end else begin
                     skew_ff[cmd.ch] <= lo_ff;
                  end
               end
            endcase
         end
         OP_OUT: begin
            omean_ff <= mean_ff;
            odev_ff <= dev_ff;
            oskew_ff <= skew_ff;
            oflat_ff <= flat_ff;
            omany_ff <= dropped;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.mul_done = mul_done;
   assign stat.srch_done = (lo_ff == hi_ff);
   assign stat.out_full = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hue_mean = omean_ff[0];
   assign rsp_sat_mean = omean_ff[1];
   assign rsp_bright_mean = omean_ff[2];
   assign rsp_hue_dev = odev_ff[0];
   assign rsp_sat_dev = odev_ff[1];
   assign rsp_bright_dev = odev_ff[2];
   assign rsp_hue_skew = $signed(oskew_ff[0]);
   assign rsp_sat_skew = $signed(oskew_ff[1]);
   assign rsp_bright_skew = $signed(oskew_ff[2]);
   assign rsp_flat_flags = oflat_ff;
   assign rsp_too_many = omany_ff;

endmodule

@@ rtl/hsvcm_ctrl.sv @@
`timescale 1ns / 1ps
module hsvcm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  hsvcm_pkg::acc_stat_type   acc_stat,
   input  hsvcm_pkg::dp_stat_type    stat,
   output hsvcm_pkg::dp_cmd_type     cmd,
   output logic                      acc_clear,
   output logic                      req_ready
);
   import hsvcm_pkg::*;

   typedef enum logic [6:0] {
      ST_ACC   = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_MWAIT = 7'b0000100,
      ST_SINIT = 7'b0001000,
      ST_SCHK  = 7'b0010000,
      ST_SWAIT = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   srch_type            srch_ff, srch_in;
   ustep_type           us;

   assign us = ustep(step_ff);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      ch_in = ch_ff;
      srch_in = srch_ff;
      acc_clear = 1'b0;
      cmd = '{op: OP_NOP, opa: us.opa, opb: us.opb, dst: us.dst,
              srch: srch_ff, ch: ch_ff};
      case (state_ff)
         ST_ACC: begin
            if (acc_stat.fin) begin
               ch_in = '0;
               step_in = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.op = OP_LOAD;
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (stat.mul_done) begin
               cmd.op = OP_WRITE;
               if (step_ff == STEP_W'(NUM_STEPS-1)) begin
                  srch_in = SRCH_MEAN;
                  state_in = ST_SINIT;
               end else begin
                  step_in = step_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_SINIT: begin
            cmd.op = OP_SINIT;
            state_in = ST_SCHK;
         end
         ST_SCHK: begin
            if (stat.srch_done) begin
               cmd.op = OP_SSAVE;
               case (srch_ff)
                  SRCH_MEAN: begin
                     srch_in = SRCH_DEV;
                     state_in = ST_SINIT;
                  end
                  SRCH_DEV: begin
                     srch_in = SRCH_SKEW;
                     state_in = ST_SINIT;
                  end
                  default: begin
                     if (ch_ff == CH_W'(NUM_CH-1)) begin
                        state_in = ST_OUT;
                     end else begin
                        ch_in = ch_ff + 1'b1;
                        step_in = '0;
                        state_in = ST_LOAD;
                     end
                  end
               endcase
            end else begin
               cmd.op = OP_LOAD;
               case (srch_ff)
                  SRCH_MEAN: begin
                     cmd.opa = SRC_MID;
                     cmd.opb = SRC_NX2;
                  end
                  SRCH_DEV: begin
                     cmd.opa = SRC_MIDSQ;
                     cmd.opb = SRC_N2;
                  end
                  default: begin
                     cmd.opa = SRC_MIDSQ;
                     cmd.opb = SRC_NEG;
                  end
               endcase
               state_in = ST_SWAIT;
            end
         end
         ST_SWAIT: begin
            if (stat.mul_done) begin
               cmd.op = OP_SSTEP;
               state_in = ST_SCHK;
            end
         end
         ST_OUT: begin
            // wait for the previous word to drain
            if (!stat.out_full) begin
               cmd.op = OP_OUT;
               acc_clear = 1'b1;
               state_in = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         step_ff <= '0;
         ch_ff <= '0;
         srch_ff <= SRCH_MEAN;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         ch_ff <= ch_in;
         srch_ff <= srch_in;
      end
   end

   assign req_ready = (state_ff == ST_ACC) && !acc_stat.hold;

endmodule
